FILE: sv/fcfc_pkg.sv
// shared constants, codes and controller/datapath interface types
package fcfc_pkg;

  // filter depth and derived index width
  localparam int MAX_TAPS = 256;
  localparam int TAP_AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  // payload widths
  localparam int NUM_CH   = 4;
  localparam int TAP_W    = 18;
  localparam int SMP_W    = 24;
  localparam int IDX_W    = 8;
  localparam int CFG_W    = 9;
  localparam int HIST_W   = NUM_CH * SMP_W;

  // arithmetic widths: Q2.40 product, exact sum over the whole tap line
  localparam int PROD_W   = TAP_W + SMP_W;
  localparam int ACC_W    = PROD_W + TAP_AW;
  localparam int RND_SH   = 17;
  localparam int RQ_W     = ACC_W + 1 - RND_SH;

  localparam logic signed [ACC_W:0]  RND_HALF = (ACC_W + 1)'(65536);
  localparam logic signed [RQ_W-1:0] RQ_MAX   = RQ_W'(8388607);
  localparam logic signed [RQ_W-1:0] RQ_MIN   = RQ_W'(-8388608);

  // operation codes
  localparam logic OP_TAP_LOAD = 1'b0;
  localparam logic OP_SAMPLE   = 1'b1;

  // register map
  localparam int   DATA_W          = 32;
  localparam int   CFG_AW          = 3;
  localparam logic REG_ACTIVE_TAPS = 1'b0;

  // commands from controller to datapath
  typedef struct packed {
    logic              tap_we;
    logic              start;
    logic              issue;
    logic [TAP_AW-1:0] k;
    logic              load_out;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: sv/fcfc_ctrl.sv
// sequencer: accepts words, steps the tap index and hands results to the output register
module fcfc_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  logic [fcfc_pkg::CFG_W-1:0]  active_taps,
  input  fcfc_pkg::dp_sts_t           sts,
  output fcfc_pkg::dp_cmd_t           cmd
);
  import fcfc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [TAP_AW-1:0] k_r, k_nxt;
  logic [TAP_AW-1:0] m_last;
  logic              accept;

  // effective filter length minus one, zero acts as one, clamp at the line depth
  always_comb begin
    priority if (active_taps == '0) begin
      m_last = '0;
    end else if (32'(active_taps) > MAX_TAPS) begin
      m_last = TAP_AW'(MAX_TAPS - 1);
    end else begin
      m_last = TAP_AW'(active_taps - CFG_W'(1));
    end
  end

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    cmd.tap_we   = 1'b0;
    cmd.start    = 1'b0;
    cmd.issue    = 1'b0;
    cmd.k        = k_r;
    cmd.load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == OP_SAMPLE) begin
            cmd.start = 1'b1;
            k_nxt     = '0;
            state_nxt = ST_RUN;
          end else begin
            cmd.tap_we = 1'b1;
          end
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (k_r == m_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + TAP_AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

FILE: sv/fcfc_dp.sv
// datapath: tap and history memories, four multiply-accumulate lanes, round and saturate
module fcfc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fcfc_pkg::dp_cmd_t                 cmd,
  output fcfc_pkg::dp_sts_t                 sts,
  input  logic [fcfc_pkg::IDX_W-1:0]        in_tap_index,
  input  logic signed [fcfc_pkg::TAP_W-1:0] in_tap_value,
  input  logic signed [fcfc_pkg::SMP_W-1:0] in_ch0,
  input  logic signed [fcfc_pkg::SMP_W-1:0] in_ch1,
  input  logic signed [fcfc_pkg::SMP_W-1:0] in_ch2,
  input  logic signed [fcfc_pkg::SMP_W-1:0] in_ch3,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic signed [fcfc_pkg::SMP_W-1:0] out_ch0,
  output logic signed [fcfc_pkg::SMP_W-1:0] out_ch1,
  output logic signed [fcfc_pkg::SMP_W-1:0] out_ch2,
  output logic signed [fcfc_pkg::SMP_W-1:0] out_ch3,
  output logic                              out_clipped
);
  import fcfc_pkg::*;

  // memories
  logic signed [TAP_W-1:0] tap_mem  [MAX_TAPS];
  logic [HIST_W-1:0]       hist_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]     tap_vld_r;

  // frame pointers and fill count
  logic [TAP_AW-1:0] wp_r, base_r, wp_inc, slot;
  logic [TAP_AW:0]   fill_r;

  // pipeline
  logic                     rd_v_r, prod_v_r, tap_ok_r, hist_ok_r;
  logic signed [TAP_W-1:0]  tap_q;
  logic [HIST_W-1:0]        hist_q;
  logic signed [TAP_W-1:0]  tap_eff;
  logic signed [SMP_W-1:0]  smp_eff [NUM_CH];
  logic signed [PROD_W-1:0] prod_r  [NUM_CH];
  logic signed [ACC_W-1:0]  acc_r   [NUM_CH];

  // rounding and output
  logic signed [ACC_W:0]    rsum    [NUM_CH];
  logic signed [RQ_W-1:0]   rq      [NUM_CH];
  logic signed [SMP_W-1:0]  sat     [NUM_CH];
  logic [NUM_CH-1:0]        clip;
  logic signed [SMP_W-1:0]  out_r   [NUM_CH];
  logic                     clipped_r, out_valid_r;

  logic [TAP_AW-1:0] tap_addr;
  logic              tap_in_range;
  logic [HIST_W-1:0] frame_in;
  logic              hist_ok;

  assign tap_addr     = TAP_AW'(in_tap_index);
  assign tap_in_range = (32'(in_tap_index) < MAX_TAPS);
  assign frame_in     = {in_ch3, in_ch2, in_ch1, in_ch0};

  // slot of the frame k steps back from the current one
  always_comb begin
    if (base_r >= cmd.k) begin
      slot = base_r - cmd.k;
    end else begin
      slot = base_r + TAP_AW'(MAX_TAPS) - cmd.k;
    end
    wp_inc = (32'(wp_r) == MAX_TAPS - 1) ? '0 : wp_r + TAP_AW'(1);
  end

  // frames older than what was ever written read as silence
  assign hist_ok = ({1'b0, cmd.k} < fill_r);

  // tap memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.tap_we && tap_in_range) begin
      tap_mem[tap_addr] <= in_tap_value;
    end
    tap_q <= tap_mem[cmd.k];
  end

  // history memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hist_mem[wp_r] <= frame_in;
    end
    hist_q <= hist_mem[slot];
  end

  // tap valid bits, pointers, fill count, pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_vld_r <= '0;
      wp_r      <= '0;
      base_r    <= '0;
      fill_r    <= '0;
      rd_v_r    <= 1'b0;
      prod_v_r  <= 1'b0;
      tap_ok_r  <= 1'b0;
      hist_ok_r <= 1'b0;
    end else begin
      if (cmd.tap_we && tap_in_range) begin
        tap_vld_r[tap_addr] <= 1'b1;
      end
      if (cmd.start) begin
        base_r <= wp_r;
        wp_r   <= wp_inc;
        if (32'(fill_r) < MAX_TAPS) begin
          fill_r <= fill_r + (TAP_AW + 1)'(1);
        end
      end
      rd_v_r    <= cmd.issue;
      tap_ok_r  <= tap_vld_r[cmd.k];
      hist_ok_r <= hist_ok;
      prod_v_r  <= rd_v_r;
    end
  end

  // mask entries that hold no written value
  always_comb begin
    tap_eff = tap_ok_r ? tap_q : '0;
    for (int c = 0; c < NUM_CH; c++) begin
      smp_eff[c] = hist_ok_r ? $signed(hist_q[c*SMP_W +: SMP_W]) : '0;
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod_r[c] <= PROD_W'(tap_eff * smp_eff[c]);
    end
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (cmd.start) begin
        acc_r[c] <= '0;
      end else if (prod_v_r) begin
        acc_r[c] <= acc_r[c] + ACC_W'(prod_r[c]);
      end
    end
  end

  // round half up to Q1.23, then saturate
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      rsum[c] = (ACC_W + 1)'(acc_r[c]) + RND_HALF;
      rq[c]   = RQ_W'(rsum[c] >>> RND_SH);
      if (rq[c] > RQ_MAX) begin
        sat[c]  = SMP_W'(RQ_MAX);
        clip[c] = 1'b1;
      end else if (rq[c] < RQ_MIN) begin
        sat[c]  = SMP_W'(RQ_MIN);
        clip[c] = 1'b1;
      end else begin
        sat[c]  = SMP_W'(rq[c]);
        clip[c] = 1'b0;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int c = 0; c < NUM_CH; c++) begin
        out_r[c] <= sat[c];
      end
      clipped_r <= |clip;
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.pipe_busy = rd_v_r | prod_v_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid   = out_valid_r;
  assign out_ch0     = out_r[0];
  assign out_ch1     = out_r[1];
  assign out_ch2     = out_r[2];
  assign out_ch3     = out_r[3];
  assign out_clipped = clipped_r;

endmodule

FILE: sv/four_channel_fir_convolver_unit.sv
// four-channel fir filter with shared taps: top level with register port
// a sample word runs M tap steps, M the effective active_taps (1..256), then
//   drains the pipeline; tap-load words give no output word; one tap step per
//   cycle through the single read port of the tap and history memories; input
//   stalls until the result loads into the output register, a tap load does not
// reset: synchronous active low, taps and history read as zero at once
//   (valid bits and a fill count, no clearing pass), active_taps returns to 256
module four_channel_fir_convolver_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic [fcfc_pkg::IDX_W-1:0]        in_tap_index,
  input  logic signed [fcfc_pkg::TAP_W-1:0] in_tap_value,
  input  logic signed [fcfc_pkg::SMP_W-1:0] in_ch0,
  input  logic signed [fcfc_pkg::SMP_W-1:0] in_ch1,
  input  logic signed [fcfc_pkg::SMP_W-1:0] in_ch2,
  input  logic signed [fcfc_pkg::SMP_W-1:0] in_ch3,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [fcfc_pkg::SMP_W-1:0] out_ch0,
  output logic signed [fcfc_pkg::SMP_W-1:0] out_ch1,
  output logic signed [fcfc_pkg::SMP_W-1:0] out_ch2,
  output logic signed [fcfc_pkg::SMP_W-1:0] out_ch3,
  output logic                              out_clipped,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fcfc_pkg::CFG_AW-1:0]       paddr,
  input  logic [fcfc_pkg::DATA_W-1:0]       pwdata,
  output logic [fcfc_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);
  import fcfc_pkg::*;

  logic [CFG_W-1:0] active_taps_r;
  logic             reg_sel;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  assign reg_sel = (paddr[CFG_AW-1:2] == REG_ACTIVE_TAPS);
  assign pready  = 1'b1;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_taps_r <= CFG_W'(256);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      active_taps_r <= pwdata[CFG_W-1:0];
    end
  end

  // register read
  assign prdata = reg_sel ? DATA_W'(active_taps_r) : '0;

  fcfc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .active_taps  (active_taps_r),
    .sts          (sts),
    .cmd          (cmd)
  );

  fcfc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_tap_index (in_tap_index),
    .in_tap_value (in_tap_value),
    .in_ch0       (in_ch0),
    .in_ch1       (in_ch1),
    .in_ch2       (in_ch2),
    .in_ch3       (in_ch3),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_ch0      (out_ch0),
    .out_ch1      (out_ch1),
    .out_ch2      (out_ch2),
    .out_ch3      (out_ch3),
    .out_clipped  (out_clipped)
  );

endmodule

FILE: sv/fcfc_checker.sv
// port-level checks for the convolver top level and their bind
module fcfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_operation,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] out_ch0,
  input logic [23:0] out_ch1,
  input logic [23:0] out_ch2,
  input logic [23:0] out_ch3,
  input logic        out_clipped
);

  // stalled output word stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // stalled output word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_ch0) && $stable(out_ch1) &&
      $stable(out_ch2) && $stable(out_ch3) && $stable(out_clipped))
    else $error("output payload changed while stalled");

  // a sample word keeps the block busy in the next cycle
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_operation |=> in_stall)
    else $error("input taken again right after a sample word");

  // a tap load leaves the block ready
  a_tap_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_operation |=> !in_stall)
    else $error("tap load made the block busy");

  // a new output word only comes out of a busy period
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output word appeared without a sample in flight");

endmodule

bind four_channel_fir_convolver_unit fcfc_checker u_fcfc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_operation (in_operation),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_ch0      (out_ch0),
  .out_ch1      (out_ch1),
  .out_ch2      (out_ch2),
  .out_ch3      (out_ch3),
  .out_clipped  (out_clipped)
);

FILE: sim/tb_four_channel_fir_convolver_unit.sv
// testbench for the four-channel fir convolver: directed, back-pressure and random filter runs
`timescale 1ns / 1ps

module tb_four_channel_fir_convolver_unit;
  import fcfc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_MAX     = 10;
  localparam int REG_SPARE      = 1;   // index with no register behind it
  localparam int PHASE_WORDS    = 78;
  localparam int NUM_PHASES     = 12;
  localparam int HOLD_CYCLES    = 400;

  typedef logic [NUM_CH-1:0][SMP_W-1:0] frame_t;
  typedef struct packed {
    logic   clipped;
    frame_t smp;
  } filtered_t;

  // dut connections
  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_operation;
  logic [IDX_W-1:0]         in_tap_index;
  logic signed [TAP_W-1:0]  in_tap_value;
  frame_t                   in_frame;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [SMP_W-1:0]  out_ch0, out_ch1, out_ch2, out_ch3;
  logic                     out_clipped;
  logic                     psel, penable, pwrite;
  logic [CFG_AW-1:0]        paddr;
  logic [DATA_W-1:0]        pwdata;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  // filter state as the testbench sees it
  logic signed [TAP_W-1:0]  coef_mem [MAX_TAPS];
  logic signed [SMP_W-1:0]  hist_mem [MAX_TAPS][NUM_CH];
  int                       wr_slot;
  logic [CFG_W-1:0]         taps_reg;
  filtered_t                pending_frames [$];

  int mismatches;
  int quiet_cycles;
  int hold_req;
  bit tx_idle_en;
  bit rx_idle_en;

  four_channel_fir_convolver_unit uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_tap_index (in_tap_index),
    .in_tap_value (in_tap_value),
    .in_ch0       (in_frame[0]),
    .in_ch1       (in_frame[1]),
    .in_ch2       (in_frame[2]),
    .in_ch3       (in_frame[3]),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ch0      (out_ch0),
    .out_ch1      (out_ch1),
    .out_ch2      (out_ch2),
    .out_ch3      (out_ch3),
    .out_clipped  (out_clipped),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // filter length actually used
  function automatic int eff_taps();
    int m;
    m = int'(taps_reg);
    if (m == 0) m = 1;
    if (m > MAX_TAPS) m = MAX_TAPS;
    return m;
  endfunction

  // store a frame in the history, run the fir on every channel, advance the slot
  function automatic filtered_t filter_frame(input frame_t x);
    filtered_t f;
    longint    acc;
    longint    y;
    int        m;
    int        s;
    m = eff_taps();
    f.clipped = 1'b0;
    for (int ch = 0; ch < NUM_CH; ch++) hist_mem[wr_slot][ch] = x[ch];
    for (int ch = 0; ch < NUM_CH; ch++) begin
      acc = 0;
      for (int k = 0; k < m; k++) begin
        s = (wr_slot + MAX_TAPS - k) % MAX_TAPS;
        acc += longint'(coef_mem[k]) * longint'(hist_mem[s][ch]);
      end
      // round half up, then clamp to q1.23
      y = (acc + 64'sd65536) >>> 17;
      if (y > 64'sd8388607) begin
        y = 64'sd8388607;
        f.clipped = 1'b1;
      end else if (y < -64'sd8388608) begin
        y = -64'sd8388608;
        f.clipped = 1'b1;
      end
      f.smp[ch] = y[SMP_W-1:0];
    end
    wr_slot = (wr_slot + 1) % MAX_TAPS;
    return f;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("mismatch at %0t: %s", $time, what);
  endtask

  // random gap: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SMP_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return SMP_W'($urandom);
    if (r < 7) return SMP_W'(int'($urandom_range(0, 8191)) - 4096);
    if (r < 9) begin
      case ($urandom_range(0, 4))
        0: return SMP_W'(-8388608);
        1: return SMP_W'(8388607);
        2: return SMP_W'(0);
        3: return SMP_W'(-1);
        default: return SMP_W'(1);
      endcase
    end
    return SMP_W'($signed(SMP_W'($urandom)) >>> $urandom_range(1, 12));
  endfunction

  function automatic logic [TAP_W-1:0] rand_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return TAP_W'($urandom);
    if (r < 8) return TAP_W'($signed(TAP_W'($urandom)) >>> $urandom_range(3, 10));
    if (r < 9) return $urandom_range(0, 1) ? TAP_W'(-131072) : TAP_W'(131071);
    return '0;
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    for (int ch = 0; ch < NUM_CH; ch++) f[ch] = rand_sample();
    return f;
  endfunction

  function automatic frame_t mk_frame(input int a, input int b, input int c, input int d);
    frame_t f;
    f[0] = SMP_W'(a);
    f[1] = SMP_W'(b);
    f[2] = SMP_W'(c);
    f[3] = SMP_W'(d);
    return f;
  endfunction

  // offer one word, wait for it to be taken, then update the prediction
  task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [TAP_W-1:0] coef, input frame_t smp);
    int n;
    n = tx_idle_en ? pick_gap() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_tap_index <= idx;
    in_tap_value <= coef;
    in_frame     <= smp;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (op == OP_SAMPLE) pending_frames.push_back(filter_frame(smp));
    else if (int'(idx) < MAX_TAPS) coef_mem[idx] = coef;
    @(negedge clk);
  endtask

  task automatic load_tap(input int idx, input int coef);
    send_word(OP_TAP_LOAD, IDX_W'(idx), TAP_W'(coef), rand_frame());
  endtask

  task automatic push_frame(input frame_t smp);
    send_word(OP_SAMPLE, IDX_W'($urandom), rand_coef(), smp);
  endtask

  // drop valid, wait for every expected word, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (eff_taps() + 8) @(negedge clk);
  endtask

  // register write: setup cycle, then access cycle, then back to idle
  task automatic reg_write(input int idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(idx * 4);
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (idx == int'(REG_ACTIVE_TAPS)) taps_reg = CFG_W'(value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // read back active_taps and compare with the shadow copy
  task automatic reg_check();
    logic [DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_AW'(int'(REG_ACTIVE_TAPS) * 4);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    if (got[CFG_W-1:0] !== taps_reg)
      report_mismatch($sformatf("active_taps read: expected %0d, got %0d",
                                taps_reg, got[CFG_W-1:0]));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_taps(input int value);
    wait_idle();
    reg_write(int'(REG_ACTIVE_TAPS), value);
    reg_check();
  endtask

  // result checker: oldest expectation against each accepted word
  always @(posedge clk) begin
    filtered_t want;
    frame_t    got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_ch3, out_ch2, out_ch1, out_ch0};
      if (pending_frames.size() == 0) begin
        report_mismatch("output word with none expected");
      end else begin
        want = pending_frames.pop_front();
        for (int ch = 0; ch < NUM_CH; ch++)
          if (got[ch] !== want.smp[ch])
            report_mismatch($sformatf("ch%0d: expected %0d, got %0d", ch,
                                      $signed(want.smp[ch]), $signed(got[ch])));
        if (out_clipped !== want.clipped)
          report_mismatch($sformatf("clipped: expected %0b, got %0b",
                                    want.clipped, out_clipped));
      end
    end
  end

  // receiver: random stall stretches, plus a long hold when requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        out_stall <= 1'b1;
        repeat (hold_req) @(negedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat (pick_gap() + 1) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // silent history and zero taps after reset, reset length of 256
  task automatic test_after_reset();
    reg_check();
    push_frame(rand_frame());
    push_frame(mk_frame(-8388608, 8388607, -1, 1));
    push_frame(rand_frame());
  endtask

  // rounding, saturation, length limits and the spare register
  task automatic test_directed_cases();
    set_taps(0);
    load_tap(0, 1);
    push_frame(mk_frame(65536, 65535, -65536, -65537));
    load_tap(0, -131072);
    push_frame(mk_frame(-8388608, 8388607, 0, 1));
    load_tap(0, 131071);
    push_frame(mk_frame(8388607, -8388608, 4194304, -1));
    // write to an index with no register must leave active_taps alone
    wait_idle();
    reg_write(REG_SPARE, 3);
    reg_check();
    push_frame(rand_frame());
    // length above the tap line clamps to the full line
    set_taps(511);
    load_tap(255, 131071);
    load_tap(1, -131072);
    load_tap(128, int'($signed(rand_coef())));
    push_frame(mk_frame(-8388608, -8388608, -8388608, -8388608));
    push_frame(mk_frame(8388607, 8388607, 8388607, 8388607));
    push_frame(mk_frame(0, 0, 0, 0));
    set_taps(300);
    push_frame(rand_frame());
    push_frame(rand_frame());
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    set_taps(4);
    tx_idle_en = 1'b0;
    hold_req   = HOLD_CYCLES;
    @(negedge clk);
    repeat (24) push_frame(rand_frame());
    wait_idle();
  endtask

  // random words over a range of filter lengths
  task automatic test_random_lengths();
    int lengths [NUM_PHASES] = '{1, 2, 5, 16, 0, 37, 256, 511, 100, 8, 3, 0};
    int m;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) lengths[p] = $urandom_range(1, 64);
      set_taps(lengths[p]);
      m = eff_taps();
      // some phases run with no idling on either side
      tx_idle_en = (p % 3 != 0);
      rx_idle_en = (p % 3 != 0);
      for (int k = 0; k < ((m < 8) ? m : 8); k++) load_tap(k, int'($signed(rand_coef())));
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if ($urandom_range(0, 99) < 15) begin
          if ($urandom_range(0, 9) < 7)
            load_tap($urandom_range(0, m - 1), int'($signed(rand_coef())));
          else
            load_tap($urandom_range(0, MAX_TAPS - 1), int'($signed(rand_coef())));
        end else begin
          push_frame(rand_frame());
        end
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // main sequence
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_TAP_LOAD;
    in_tap_index = '0;
    in_tap_value = '0;
    in_frame     = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    hold_req     = 0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    wr_slot      = 0;
    taps_reg     = CFG_W'(256);
    for (int i = 0; i < MAX_TAPS; i++) begin
      coef_mem[i] = '0;
      for (int ch = 0; ch < NUM_CH; ch++) hist_mem[i][ch] = '0;
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_after_reset();
    test_directed_cases();
    test_backpressure();
    test_random_lengths();
    wait_idle();

    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
sv/fcfc_pkg.sv
sv/fcfc_ctrl.sv
sv/fcfc_dp.sv
sv/four_channel_fir_convolver_unit.sv
sv/fcfc_checker.sv
sim/tb_four_channel_fir_convolver_unit.sv
